>>> hw/rtl/lirs_pkg.sv
// ----------------------------------------------------------------------------
// lirs_pkg
// Shared widths, register map, reset values and the command/status types of
// the serial arithmetic unit of the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lirs_pkg;

  // Field and state widths
  localparam int unsigned SMP_W  = 16;   // Q1.15 sample
  localparam int unsigned RATE_W = 18;   // rate registers
  localparam int unsigned CLIP_W = 25;   // clip length and input index
  localparam int unsigned OIDX_W = 30;   // stored output index
  localparam int unsigned IDX_W  = 31;   // running output index within one item
  localparam int unsigned NRES_W = 7;    // results counted for one item

  // Serial arithmetic unit
  localparam int unsigned WORK_W    = IDX_W + RATE_W;  // widest product / dividend
  localparam int unsigned DVSR_W    = RATE_W + 1;      // 2*rate fits
  localparam int unsigned MUL_STEPS = RATE_W;          // one multiplier bit a cycle
  localparam int unsigned DIV_STEPS = WORK_W;          // one quotient bit a cycle
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam int unsigned MAX_RESULTS   = 64;
  localparam int unsigned MAX_RATIO_DEF = 32;

  // Offset between Q1.15 and offset binary
  localparam logic [SMP_W-1:0] SMP_OFS = 16'h8000;

  // Configuration port
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned REG_IX_W = 2;

  localparam logic [REG_IX_W-1:0] REG_SOURCE_RATE = 2'd0;
  localparam logic [REG_IX_W-1:0] REG_TARGET_RATE = 2'd1;
  localparam logic [REG_IX_W-1:0] REG_CLIP_LEN    = 2'd2;

  localparam logic [RATE_W-1:0] SOURCE_RATE_RST = 18'd24000;
  localparam logic [RATE_W-1:0] TARGET_RATE_RST = 18'd24000;
  localparam logic [CLIP_W-1:0] CLIP_LEN_RST    = 25'd1;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } arith_op_t;

  // mul: work = ma*mpa + mb*mpb ; div: work = dvnd / dvsr, rem = dvnd % dvsr
  typedef struct packed {
    logic                  go;
    arith_op_t             op;
    logic [IDX_W-1:0]      ma;
    logic [SMP_W-1:0]      mb;
    logic [RATE_W-1:0]     mpa;
    logic [RATE_W-1:0]     mpb;
    logic [WORK_W-1:0]     dvnd;
    logic [DVSR_W-1:0]     dvsr;
  } arith_cmd_t;

  typedef struct packed {
    logic                  done;
    logic [WORK_W-1:0]     work;
    logic [DVSR_W-1:0]     rem;
  } arith_sts_t;

endpackage

>>> hw/rtl/lirs_cfg.sv
// ----------------------------------------------------------------------------
// lirs_cfg
// APB-style register file: source rate, target rate and clip length.
// ----------------------------------------------------------------------------
module lirs_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lirs_pkg::APB_AW-1:0]   paddr,
  input  logic [lirs_pkg::APB_DW-1:0]   pwdata,
  output logic [lirs_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [lirs_pkg::RATE_W-1:0]   source_rate,
  output logic [lirs_pkg::RATE_W-1:0]   target_rate,
  output logic [lirs_pkg::CLIP_W-1:0]   clip_len
);

  logic [lirs_pkg::RATE_W-1:0]   source_rate_r, source_rate_nxt;
  logic [lirs_pkg::RATE_W-1:0]   target_rate_r, target_rate_nxt;
  logic [lirs_pkg::CLIP_W-1:0]   clip_len_r, clip_len_nxt;
  logic [lirs_pkg::REG_IX_W-1:0] reg_ix;
  logic                          wr_en;

  assign pready = 1'b1;
  assign reg_ix = paddr[lirs_pkg::APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    source_rate_nxt = source_rate_r;
    target_rate_nxt = target_rate_r;
    clip_len_nxt    = clip_len_r;
    if (wr_en) begin
      case (reg_ix)
        lirs_pkg::REG_SOURCE_RATE: source_rate_nxt = pwdata[lirs_pkg::RATE_W-1:0];
        lirs_pkg::REG_TARGET_RATE: target_rate_nxt = pwdata[lirs_pkg::RATE_W-1:0];
        lirs_pkg::REG_CLIP_LEN:    clip_len_nxt    = pwdata[lirs_pkg::CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_ix)
      lirs_pkg::REG_SOURCE_RATE: prdata = lirs_pkg::APB_DW'(source_rate_r);
      lirs_pkg::REG_TARGET_RATE: prdata = lirs_pkg::APB_DW'(target_rate_r);
      lirs_pkg::REG_CLIP_LEN:    prdata = lirs_pkg::APB_DW'(clip_len_r);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_rate_r <= lirs_pkg::SOURCE_RATE_RST;
      target_rate_r <= lirs_pkg::TARGET_RATE_RST;
      clip_len_r    <= lirs_pkg::CLIP_LEN_RST;
    end else begin
      source_rate_r <= source_rate_nxt;
      target_rate_r <= target_rate_nxt;
      clip_len_r    <= clip_len_nxt;
    end
  end

  assign source_rate = source_rate_r;
  assign target_rate = target_rate_r;
  assign clip_len    = clip_len_r;

endmodule

>>> hw/rtl/lirs_arith.sv
// ----------------------------------------------------------------------------
// lirs_arith
// Shared bit-serial unit: dual shift-add multiply (one multiplier bit per
// cycle, MSB first) and restoring divide (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module lirs_arith (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lirs_pkg::arith_cmd_t  cmd,
  output lirs_pkg::arith_sts_t  sts
);

  localparam int unsigned CW = lirs_pkg::CNT_W;
  localparam int unsigned WW = lirs_pkg::WORK_W;
  localparam int unsigned DW = lirs_pkg::DVSR_W;
  localparam int unsigned RW = lirs_pkg::RATE_W;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  lirs_pkg::arith_op_t           op_r, op_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [WW-1:0]                 work_r, work_nxt;
  logic [DW-1:0]                 rem_r, rem_nxt;
  logic [DW-1:0]                 dvsr_r, dvsr_nxt;
  logic [lirs_pkg::IDX_W-1:0]    ma_r, ma_nxt;
  logic [lirs_pkg::SMP_W-1:0]    mb_r, mb_nxt;
  logic [RW-1:0]                 mpa_r, mpa_nxt;
  logic [RW-1:0]                 mpb_r, mpb_nxt;

  logic [DW+1:0]                 trial;
  logic [WW-1:0]                 mul_sum;
  logic [CW-1:0]                 cnt_last;

  // trial subtract of the divisor from the partial remainder with the next bit
  assign trial   = {1'b0, rem_r, work_r[WW-1]} - {2'b00, dvsr_r};
  assign mul_sum = {work_r[WW-2:0], 1'b0}
                 + (mpa_r[RW-1] ? WW'(ma_r) : '0)
                 + (mpb_r[RW-1] ? WW'(mb_r) : '0);
  assign cnt_last = (op_r == lirs_pkg::OP_MUL) ? CW'(lirs_pkg::MUL_STEPS - 1)
                                               : CW'(lirs_pkg::DIV_STEPS - 1);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    mpa_nxt  = mpa_r;
    mpb_nxt  = mpb_r;
    if (!busy_r) begin
      if (cmd.go) begin
        busy_nxt = 1'b1;
        op_nxt   = cmd.op;
        cnt_nxt  = '0;
        ma_nxt   = cmd.ma;
        mb_nxt   = cmd.mb;
        mpa_nxt  = cmd.mpa;
        mpb_nxt  = cmd.mpb;
        dvsr_nxt = cmd.dvsr;
        rem_nxt  = '0;
        work_nxt = (cmd.op == lirs_pkg::OP_MUL) ? '0 : cmd.dvnd;
      end
    end else begin
      if (op_r == lirs_pkg::OP_MUL) begin
        work_nxt = mul_sum;
        mpa_nxt  = {mpa_r[RW-2:0], 1'b0};
        mpb_nxt  = {mpb_r[RW-2:0], 1'b0};
      end else begin
        if (!trial[DW+1]) begin
          rem_nxt  = trial[DW-1:0];
          work_nxt = {work_r[WW-2:0], 1'b1};
        end else begin
          rem_nxt  = {rem_r[DW-2:0], work_r[WW-1]};
          work_nxt = {work_r[WW-2:0], 1'b0};
        end
      end
      if (cnt_r == cnt_last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= lirs_pkg::OP_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    mpa_r  <= mpa_nxt;
    mpb_r  <= mpb_nxt;
  end

  assign sts.done = done_r;
  assign sts.work = work_r;
  assign sts.rem  = rem_r;

endmodule

>>> hw/rtl/linear_interp_resampler_unit.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit
// Linear interpolation sample rate converter for one clip of Q1.15 samples.
//
//   channel  direction  handshake           payload
//   in_      slave      tvalid/tready       tdata: sample_in
//   out_     master     tvalid/tready       tdata: sample_out, tlast: final_of_run,
//                                           tuser: error_flag
//   cfg_     APB slave  psel/penable/pready source_rate, target_rate, clip_length
//
// One item at a time through one bit-serial multiply/divide unit. Error and
// equal-rate items go straight to sending; else a multiply and a divide give
// the output total, each interpolated result two 18-step multiplies and two
// 49-step divides, a flushed result or the end probe one pair; then finish/send.
// Synchronous active-low reset clears the clip position. A stalled output parks
// the unit at the next result, one result waiting in each of hold and output.
// ----------------------------------------------------------------------------
module linear_interp_resampler_unit #(
  parameter int unsigned MAX_RATIO = lirs_pkg::MAX_RATIO_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: [15:0] sample_in
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic signed [lirs_pkg::SMP_W-1:0] in_tdata,
  // out_tdata: [15:0] sample_out
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic signed [lirs_pkg::SMP_W-1:0] out_tdata,
  output logic                              out_tlast,
  // out_tuser: [0] error_flag
  output logic                              out_tuser,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lirs_pkg::APB_AW-1:0]       cfg_paddr,
  input  logic [lirs_pkg::APB_DW-1:0]       cfg_pwdata,
  output logic [lirs_pkg::APB_DW-1:0]       cfg_prdata,
  output logic                              cfg_pready
);

  localparam int unsigned SW  = lirs_pkg::SMP_W;
  localparam int unsigned RW  = lirs_pkg::RATE_W;
  localparam int unsigned LW  = lirs_pkg::CLIP_W;
  localparam int unsigned OW  = lirs_pkg::OIDX_W;
  localparam int unsigned IW  = lirs_pkg::IDX_W;
  localparam int unsigned NW  = lirs_pkg::NRES_W;
  localparam int unsigned WW  = lirs_pkg::WORK_W;
  localparam int unsigned TW  = LW + $clog2(MAX_RATIO);          // output total
  localparam int unsigned LMW = RW + $clog2(MAX_RATIO + 1);      // ratio limit

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOT_MUL,
    ST_TOT_DIV,
    ST_CHECK,
    ST_POS_MUL,
    ST_POS_DIV,
    ST_INT_MUL,
    ST_INT_DIV,
    ST_RESULT,
    ST_FINISH,
    ST_SEND
  } state_t;

  logic [RW-1:0] source_rate;
  logic [RW-1:0] target_rate;
  logic [LW-1:0] clip_len;

  lirs_pkg::arith_cmd_t cmd;
  lirs_pkg::arith_sts_t sts;

  state_t        state_r, state_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic [SW-1:0] prev_r, prev_nxt;
  logic [LW-1:0] in_idx_r, in_idx_nxt;
  logic [OW-1:0] out_idx_r, out_idx_nxt;
  logic          last_r, last_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [SW-1:0] val_r, val_nxt;
  logic          hold_vld_r, hold_vld_nxt;
  logic [SW-1:0] hold_smp_r, hold_smp_nxt;
  logic          hold_err_r, hold_err_nxt;
  logic          out_vld_r, out_vld_nxt;
  logic [SW-1:0] out_smp_r, out_smp_nxt;
  logic          out_fin_r, out_fin_nxt;
  logic          out_err_r, out_err_nxt;

  logic           in_acc;
  logic           out_free;
  logic [LMW-1:0] ratio_lim;
  logic           bad_item;
  logic           same_rate;
  logic           last_now;
  logic [RW-1:0]  frac;

  lirs_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .source_rate (source_rate),
    .target_rate (target_rate),
    .clip_len    (clip_len)
  );

  lirs_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;
  assign ratio_lim = LMW'(source_rate) * LMW'(MAX_RATIO);
  assign bad_item  = (source_rate == '0) || (target_rate == '0)
                  || (LMW'(target_rate) > ratio_lim) || (in_idx_r >= clip_len);
  assign same_rate = (source_rate == target_rate);
  assign last_now  = ({1'b0, in_idx_r} + (LW+1)'(1)) == {1'b0, clip_len};
  assign frac      = sts.rem[RW-1:0];

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    in_idx_nxt   = in_idx_r;
    out_idx_nxt  = out_idx_r;
    last_nxt     = last_r;
    total_nxt    = total_r;
    i_nxt        = i_r;
    n_nxt        = n_r;
    val_nxt      = val_r;
    hold_vld_nxt = hold_vld_r;
    hold_smp_nxt = hold_smp_r;
    hold_err_nxt = hold_err_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_smp_nxt  = out_smp_r;
    out_fin_nxt  = out_fin_r;
    out_err_nxt  = out_err_r;
    cmd          = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cur_nxt = in_tdata;
          if (bad_item) begin
            hold_vld_nxt = 1'b1;
            hold_smp_nxt = '0;
            hold_err_nxt = 1'b1;
            state_nxt    = ST_SEND;
          end else if (same_rate) begin
            hold_vld_nxt = 1'b1;
            hold_smp_nxt = in_tdata;
            hold_err_nxt = 1'b0;
            prev_nxt     = in_tdata;
            in_idx_nxt   = in_idx_r + 1'b1;
            out_idx_nxt  = out_idx_r + 1'b1;
            state_nxt    = ST_SEND;
          end else begin
            // output total = round(clip_len * target / source), ties up
            last_nxt  = last_now;
            cmd.go    = 1'b1;
            cmd.op    = lirs_pkg::OP_MUL;
            cmd.ma    = IW'(clip_len);
            cmd.mpa   = target_rate;
            state_nxt = ST_TOT_MUL;
          end
        end
      end
      ST_TOT_MUL: begin
        if (sts.done) begin
          cmd.go    = 1'b1;
          cmd.op    = lirs_pkg::OP_DIV;
          cmd.dvnd  = {sts.work[WW-2:0], 1'b0} + WW'(source_rate);
          cmd.dvsr  = {source_rate, 1'b0};
          state_nxt = ST_TOT_DIV;
        end
      end
      ST_TOT_DIV: begin
        if (sts.done) begin
          total_nxt = sts.work[TW-1:0];
          i_nxt     = IW'(out_idx_r);
          n_nxt     = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ((i_r < IW'(total_r)) && (n_r < NW'(lirs_pkg::MAX_RESULTS))) begin
          cmd.go    = 1'b1;
          cmd.op    = lirs_pkg::OP_MUL;
          cmd.ma    = i_r;
          cmd.mpa   = source_rate;
          state_nxt = ST_POS_MUL;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_POS_MUL: begin
        if (sts.done) begin
          cmd.go    = 1'b1;
          cmd.op    = lirs_pkg::OP_DIV;
          cmd.dvnd  = sts.work;
          cmd.dvsr  = {1'b0, target_rate};
          state_nxt = ST_POS_DIV;
        end
      end
      ST_POS_DIV: begin
        if (sts.done) begin
          if (sts.work < WW'(in_idx_r)) begin
            // offset binary: u = a'*(d-r) + b'*r
            cmd.go    = 1'b1;
            cmd.op    = lirs_pkg::OP_MUL;
            cmd.ma    = IW'(prev_r ^ lirs_pkg::SMP_OFS);
            cmd.mpa   = target_rate - frac;
            cmd.mb    = cur_r ^ lirs_pkg::SMP_OFS;
            cmd.mpb   = frac;
            state_nxt = ST_INT_MUL;
          end else if (last_r) begin
            val_nxt   = cur_r;
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_INT_MUL: begin
        if (sts.done) begin
          // round to nearest: (2u + d) / 2d
          cmd.go    = 1'b1;
          cmd.op    = lirs_pkg::OP_DIV;
          cmd.dvnd  = {sts.work[WW-2:0], 1'b0} + WW'(target_rate);
          cmd.dvsr  = {target_rate, 1'b0};
          state_nxt = ST_INT_DIV;
        end
      end
      ST_INT_DIV: begin
        if (sts.done) begin
          val_nxt   = sts.work[SW-1:0] ^ lirs_pkg::SMP_OFS;
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        // one result is held back so that the last one can carry tlast
        if (!hold_vld_r) begin
          hold_vld_nxt = 1'b1;
          hold_smp_nxt = val_r;
          hold_err_nxt = 1'b0;
          i_nxt        = i_r + 1'b1;
          n_nxt        = n_r + 1'b1;
          state_nxt    = ST_CHECK;
        end else if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_smp_nxt  = hold_smp_r;
          out_fin_nxt  = 1'b0;
          out_err_nxt  = hold_err_r;
          hold_smp_nxt = val_r;
          i_nxt        = i_r + 1'b1;
          n_nxt        = n_r + 1'b1;
          state_nxt    = ST_CHECK;
        end
      end
      ST_FINISH: begin
        prev_nxt    = cur_r;
        in_idx_nxt  = in_idx_r + 1'b1;
        out_idx_nxt = last_r ? OW'(total_r) : i_r[OW-1:0];
        state_nxt   = hold_vld_r ? ST_SEND : ST_IDLE;
      end
      ST_SEND: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_smp_nxt  = hold_smp_r;
          out_fin_nxt  = 1'b1;
          out_err_nxt  = hold_err_r;
          hold_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      prev_r     <= '0;
      in_idx_r   <= '0;
      out_idx_r  <= '0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      prev_r     <= prev_nxt;
      in_idx_r   <= in_idx_nxt;
      out_idx_r  <= out_idx_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    cur_r      <= cur_nxt;
    last_r     <= last_nxt;
    total_r    <= total_nxt;
    i_r        <= i_nxt;
    n_r        <= n_nxt;
    val_r      <= val_nxt;
    hold_smp_r <= hold_smp_nxt;
    hold_err_r <= hold_err_nxt;
    out_smp_r  <= out_smp_nxt;
    out_fin_r  <= out_fin_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_smp_r;
  assign out_tlast  = out_fin_r;
  assign out_tuser  = out_err_r;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear interpolation resampler testbench
// Drives Q1.15 samples into linear_interp_resampler_unit through a single
// long clip, retuning the rates and clip length over APB between phases.
// A scoreboard predicts every interpolated output, flush and rejection, and
// compares each accepted output item field by field.
// ----------------------------------------------------------------------------
module testbench;
  import lirs_pkg::*;

  localparam int    ITEMS  = 470;
  localparam int    SETTLE = 600;    // covers the total/probe pass of an item with no output
  localparam longint RATIO_CAP = MAX_RATIO_DEF;
  localparam logic signed [SMP_W-1:0] Q15_MAX = 16'sh7fff;
  localparam logic signed [SMP_W-1:0] Q15_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [SMP_W-1:0] smp;
    logic                    fin;
    logic                    err;
  } resampled_t;

  class resample_scoreboard;
    logic [RATE_W-1:0]       source_rate;
    logic [RATE_W-1:0]       target_rate;
    logic [CLIP_W-1:0]       clip_len;
    logic signed [SMP_W-1:0] prev_smp;
    logic [CLIP_W-1:0]       in_idx;
    logic [OIDX_W-1:0]       out_idx;
    resampled_t              pending_out[$];
    int taken, checked, mismatches, rejected, clip_ends, most_per_item;

    function new();
      source_rate = SOURCE_RATE_RST;
      target_rate = TARGET_RATE_RST;
      clip_len    = CLIP_LEN_RST;
      prev_smp    = '0;
      in_idx      = '0;
      out_idx     = '0;
    endfunction

    function void flag(string what, logic signed [31:0] want, logic signed [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR %s: expected %0d, got %0d (after %0d outputs)", what, want, got,
                 checked);
    endfunction

    function void set_reg(logic [REG_IX_W-1:0] idx, logic [APB_DW-1:0] v);
      case (idx)
        REG_SOURCE_RATE: source_rate = v[RATE_W-1:0];
        REG_TARGET_RATE: target_rate = v[RATE_W-1:0];
        REG_CLIP_LEN:    clip_len    = v[CLIP_W-1:0];
        default: ;
      endcase
    endfunction

    function void check_reg(logic [REG_IX_W-1:0] idx, logic [APB_DW-1:0] got);
      logic [APB_DW-1:0] want;
      case (idx)
        REG_SOURCE_RATE: want = APB_DW'(source_rate);
        REG_TARGET_RATE: want = APB_DW'(target_rate);
        default:         want = APB_DW'(clip_len);
      endcase
      if (got !== want) flag("register readback", want, got);
    endfunction

    function void queue_sample(logic signed [SMP_W-1:0] v, logic fin, logic err);
      resampled_t e;
      e.smp = v;
      e.fin = fin;
      e.err = err;
      pending_out.push_back(e);
    endfunction

    // a + (b-a)*r/d rounded to nearest, ties up; worked in offset binary so it stays >= 0
    function logic signed [SMP_W-1:0] lerp_q15(longint a, longint b, longint r, longint d);
      longint u;
      longint q;
      u = (a + 32768) * d + (b - a) * r;
      q = (2 * u + d) / (2 * d);
      return SMP_W'(q - 32768);
    endfunction

    // One accepted input item: work out every output it releases
    function void take_sample(logic signed [SMP_W-1:0] x);
      longint s, d, k, total, i, pos, i0, r;
      int n;
      bit last;
      logic signed [SMP_W-1:0] v;
      resampled_t tail;
      s = source_rate;
      d = target_rate;
      k = in_idx;
      n = 0;
      taken++;
      if (s == 0 || d == 0 || d > RATIO_CAP * s || k >= longint'(clip_len)) begin
        queue_sample('0, 1'b1, 1'b1);
        rejected++;
        return;
      end
      last = (k + 1 == longint'(clip_len));
      if (s == d) begin
        queue_sample(x, 1'b1, 1'b0);
        prev_smp = x;
        in_idx   = CLIP_W'(k + 1);
        out_idx  = out_idx + 1'b1;
        if (last) clip_ends++;
        return;
      end
      total = (2 * longint'(clip_len) * d + s) / (2 * s);
      i = out_idx;
      while (i < total && n < int'(MAX_RESULTS)) begin
        pos = i * s;
        i0  = pos / d;
        r   = pos % d;
        if (i0 < k) v = lerp_q15(prev_smp, x, r, d);
        else if (last) v = x;   // flush: neighbour clamped to the last sample
        else break;
        queue_sample(v, 1'b0, 1'b0);
        n++;
        i++;
      end
      if (last) begin
        i = total;
        clip_ends++;
      end
      if (n > 0) begin
        tail = pending_out.pop_back();
        tail.fin = 1'b1;
        pending_out.push_back(tail);
      end
      if (n > most_per_item) most_per_item = n;
      out_idx  = OIDX_W'(i);
      prev_smp = x;
      in_idx   = CLIP_W'(k + 1);
    endfunction

    function void check_output(logic signed [SMP_W-1:0] smp, logic fin, logic err);
      resampled_t want;
      if (pending_out.size() == 0) begin
        flag("output item with none expected, sample_out", 'x, smp);
        return;
      end
      want = pending_out.pop_front();
      checked++;
      if (smp !== want.smp) flag("sample_out", want.smp, smp);
      if (fin !== want.fin) flag("final_of_run (tlast)", want.fin, fin);
      if (err !== want.err) flag("error_flag (tuser)", want.err, err);
    endfunction

    function int failures();
      if (pending_out.size() != 0)
        $display("ERROR %0d expected outputs never arrived", pending_out.size());
      return mismatches + pending_out.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic signed [SMP_W-1:0]  in_tdata = '0;       // [15:0] sample_in
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic signed [SMP_W-1:0]  out_tdata;           // [15:0] sample_out
  logic                     out_tlast;
  logic                     out_tuser;           // [0] error_flag
  logic                     cfg_psel = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite = 1'b0;
  logic [APB_AW-1:0]        cfg_paddr = '0;
  logic [APB_DW-1:0]        cfg_pwdata = '0;
  logic [APB_DW-1:0]        cfg_prdata;
  logic                     cfg_pready;

  resample_scoreboard sb;
  int unsigned max_stall = 0;
  int unsigned rx_left = 0;
  bit          rx_on = 1'b0;
  int          burst_left = 0;
  int          sent = 0;
  int          last_drawn = 0;
  int unsigned std_rates[12] = '{8000, 11025, 16000, 22050, 24000, 32000,
                                 44100, 48000, 88200, 96000, 176400, 192000};
  int unsigned corner_src[8] = '{192000, 6000, 1, 1, 192000, 44100, 48000, 192000};
  int unsigned corner_dst[8] = '{6000, 192000, 32, 1, 1, 48000, 44100, 192000};

  linear_interp_resampler_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Handshakes are sampled with pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.take_sample(in_tdata);
      if (out_tvalid && out_tready) sb.check_output(out_tdata, out_tlast, out_tuser);
    end
  end

  // Receiver: alternating ready and stall stretches; no stalls when max_stall is 0
  always @(posedge clk) begin
    if (rx_left != 0) begin
      rx_left = rx_left - 1;
    end else begin
      rx_on = (max_stall == 0) ? 1'b1 : !rx_on;
      rx_left = rx_on ? $urandom_range(1, 24) : $urandom_range(1, max_stall);
      out_tready <= rx_on;
    end
  end

  function automatic logic signed [SMP_W-1:0] next_sample();
    int unsigned pick;
    int v;
    pick = $urandom_range(0, 19);
    if (pick < 2) v = -32768;
    else if (pick < 4) v = 32767;
    else if (pick < 9) v = last_drawn + int'($urandom_range(0, 512)) - 256;
    else v = int'($urandom_range(0, 65535)) - 32768;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    last_drawn = v;
    return SMP_W'(v);
  endfunction

  function automatic int unsigned pick_rate();
    if ($urandom_range(0, 1) == 0) return std_rates[$urandom_range(0, 11)];
    return $urandom_range(1, 192000);
  endfunction

  task automatic send_sample(input logic signed [SMP_W-1:0] x);
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic feed(input int count);
    for (int j = 0; j < count; j++) begin
      if (burst_left == 0) begin
        in_tvalid <= 1'b0;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 300)) @(posedge clk);
        else repeat ($urandom_range(1, 10)) @(posedge clk);
        burst_left = $urandom_range(1, 8);
      end
      send_sample(next_sample());
      burst_left--;
    end
  endtask

  // Hold the sender until every expected output is back, then let the unit settle
  task automatic drain(input int settle);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_out.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Write one register, then read it back
  task automatic cfg_write(input logic [REG_IX_W-1:0] idx, input logic [APB_DW-1:0] v);
    logic [APB_DW-1:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, v);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    sb.check_reg(idx, got);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    #100_000_000;
    $display("linear_interp_resampler_unit: mismatch");
    $finish;
  end

  initial begin
    int unsigned s, d, n, kind;
    int phases;
    sb = new();
    phases = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: equal rates, one-sample clip, then one item past its end
    send_sample(Q15_MAX);
    send_sample(Q15_MIN);
    drain(SETTLE);
    cfg_write(REG_CLIP_LEN, 32'd16777216);
    send_sample(Q15_MIN);
    send_sample('0);
    // zero source, zero target, ratio just above the cap
    drain(SETTLE);
    cfg_write(REG_SOURCE_RATE, 32'd0);
    send_sample(16'sd1);
    drain(SETTLE);
    cfg_write(REG_SOURCE_RATE, 32'd1000);
    cfg_write(REG_TARGET_RATE, 32'd0);
    send_sample(-16'sd1);
    drain(SETTLE);
    cfg_write(REG_TARGET_RATE, 32'd32001);
    send_sample(16'sd12345);
    // ratio 32 mid-clip: the output falls far behind and the first item hits the per-item cap
    drain(SETTLE);
    cfg_write(REG_TARGET_RATE, 32'd32000);
    send_sample(Q15_MIN);
    send_sample(Q15_MAX);
    send_sample(Q15_MIN);
    send_sample(Q15_MAX);
    // downsample by 32 while well ahead: items with no output due
    drain(SETTLE);
    cfg_write(REG_SOURCE_RATE, 32'd192000);
    cfg_write(REG_TARGET_RATE, 32'd6000);
    send_sample(16'sd12345);
    send_sample(-16'sd12345);
    drain(SETTLE);
    cfg_write(REG_CLIP_LEN, 32'd1);
    send_sample(16'sd7);

    // Phases: retune, end the clip on one item to resync the output position,
    // then extend the clip for a run of random samples
    while (sent < ITEMS) begin
      kind = 2;
      if (phases < 8) begin
        s = corner_src[phases];
        d = corner_dst[phases];
      end else begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          case ($urandom_range(0, 2))
            0: begin s = 0; d = $urandom_range(1, 192000); end
            1: begin s = $urandom_range(1, 192000); d = 0; end
            default: begin
              s = $urandom_range(1, 5999);
              d = $urandom_range(32 * s + 1, 192000);
            end
          endcase
        end else if (kind == 1) begin
          s = pick_rate();
          d = s;
        end else begin
          do begin
            s = pick_rate();
            d = pick_rate();
          end while (d == s || d > 32 * s);
        end
      end
      n = (kind == 0) ? $urandom_range(2, 5) : $urandom_range(4, 40);
      while (n > 2 && longint'(n) * d > 64 * longint'(s)) n = n / 2;
      case ($urandom_range(0, 4))
        0, 1:    max_stall = 0;
        2:       max_stall = 3;
        3:       max_stall = 12;
        default: max_stall = 40;
      endcase

      drain(SETTLE);
      cfg_write(REG_SOURCE_RATE, s);
      cfg_write(REG_TARGET_RATE, d);
      cfg_write(REG_CLIP_LEN, sb.in_idx + 1);
      feed(1);
      drain(SETTLE);
      cfg_write(REG_CLIP_LEN, sb.in_idx + n);
      // now and then run past the end of the clip
      feed(n + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0));
      phases++;
    end

    drain(SETTLE);
    $display("Covered %0d input items (%0d rejected, %0d clip ends) over %0d rate settings,",
             sb.taken, sb.rejected, sb.clip_ends, phases + 6);
    $display("checking %0d output items, at most %0d released by one item.",
             sb.checked, sb.most_per_item);
    if (sb.failures() == 0) begin
      $display("linear_interp_resampler_unit: match");
    end else begin
      $display("linear_interp_resampler_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> linear_interp_resampler_unit.f
hw/rtl/lirs_pkg.sv
hw/rtl/lirs_cfg.sv
hw/rtl/lirs_arith.sv
hw/rtl/linear_interp_resampler_unit.sv
test/testbench.sv
